FILE: rtl/core/kpbt_pkg.sv
package kpbt_pkg;

  localparam int TABLE_DEPTH_DEF  = 64;
  localparam int KEY_BITS_DEF     = 16;
  localparam int WEIGHT_FRAC_DEF  = 16;

  // key compare lanes, slot = row * NUM_LANES + lane
  localparam int NUM_LANES = 16;
  localparam int LANE_W    = 4;

  localparam int NCOORD  = 6;
  localparam int COORD_W = 32;
  localparam int IDX_W   = 6;
  localparam int PART_W  = 16;

  typedef enum logic [1:0] {
    CMD_BLEND  = 2'd0,
    CMD_LOAD   = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_LOOKUP = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_DIFF,
    ST_MUL,
    ST_ADD,
    ST_RESP
  } state_e;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef coord_t [NCOORD-1:0] pose_t;

  typedef struct packed {
    cmd_e                      cmd;
    logic [PART_W-1:0]         part_id;
    logic signed [COORD_W-1:0] in_pos_x;
    logic signed [COORD_W-1:0] in_pos_y;
    logic signed [COORD_W-1:0] in_pos_z;
    logic signed [COORD_W-1:0] in_rot_x;
    logic signed [COORD_W-1:0] in_rot_y;
    logic signed [COORD_W-1:0] in_rot_z;
    logic                      add_if_missing;
  } req_t;

  typedef struct packed {
    logic [PART_W-1:0]         out_part_id;
    logic signed [COORD_W-1:0] out_pos_x;
    logic signed [COORD_W-1:0] out_pos_y;
    logic signed [COORD_W-1:0] out_pos_z;
    logic signed [COORD_W-1:0] out_rot_x;
    logic signed [COORD_W-1:0] out_rot_y;
    logic signed [COORD_W-1:0] out_rot_z;
    logic                      hit;
    logic                      overflow;
    logic [IDX_W-1:0]          entry_index;
  } rsp_t;

  typedef struct packed {
    logic start;
    logic cmp_valid;
    logic highest;
  } merge_ctl_t;

  function automatic pose_t req_pose(req_t r);
    pose_t p;
    p[0] = r.in_pos_x;
    p[1] = r.in_pos_y;
    p[2] = r.in_pos_z;
    p[3] = r.in_rot_x;
    p[4] = r.in_rot_y;
    p[5] = r.in_rot_z;
    return p;
  endfunction

  function automatic rsp_t rsp_set_pose(rsp_t r, pose_t p);
    rsp_t o;
    o = r;
    o.out_pos_x = p[0];
    o.out_pos_y = p[1];
    o.out_pos_z = p[2];
    o.out_rot_x = p[3];
    o.out_rot_y = p[4];
    o.out_rot_z = p[5];
    return o;
  endfunction

endpackage

FILE: rtl/core/kpbt_key_lane.sv
module kpbt_key_lane #(
  parameter int KEY_BITS = kpbt_pkg::KEY_BITS_DEF,
  parameter int ROWS     = 4,
  parameter int ROW_W    = 2,
  parameter int CNT_W    = 7,
  parameter int LANE_IDX = 0
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [ROW_W-1:0]    waddr_i,
  input  logic [KEY_BITS-1:0] wkey_i,
  input  logic [ROW_W-1:0]    raddr_i,
  input  logic [KEY_BITS-1:0] key_i,
  input  logic [CNT_W-1:0]    count_i,
  input  logic [ROW_W-1:0]    cmp_row_i,
  output logic                match_o
);

  localparam int CMP_W = ROW_W + kpbt_pkg::LANE_W + CNT_W;

  logic [KEY_BITS-1:0] mem [ROWS];
  logic [KEY_BITS-1:0] rdata_q;
  logic                live;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wkey_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  // only slots below the fill count hold entries
  assign live = CMP_W'({cmp_row_i, kpbt_pkg::LANE_W'(LANE_IDX)}) < CMP_W'(count_i);
  assign match_o = live && (rdata_q == key_i);

endmodule

FILE: rtl/core/kpbt_merge.sv
module kpbt_merge #(
  parameter int ROW_W = 2
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  kpbt_pkg::merge_ctl_t                 ctl_i,
  input  logic [ROW_W-1:0]                     row_i,
  input  logic [kpbt_pkg::NUM_LANES-1:0]       match_i,
  output logic                                 found_o,
  output logic [ROW_W+kpbt_pkg::LANE_W-1:0]    slot_o
);

  logic                        found_q;
  logic [ROW_W+kpbt_pkg::LANE_W-1:0] slot_q;
  logic [kpbt_pkg::LANE_W-1:0] lo_idx;
  logic [kpbt_pkg::LANE_W-1:0] hi_idx;
  logic                        any;
  logic                        take;

  always_comb begin
    lo_idx = '0;
    hi_idx = '0;
    for (int l = kpbt_pkg::NUM_LANES - 1; l >= 0; l--) begin
      if (match_i[l]) begin
        lo_idx = kpbt_pkg::LANE_W'(l);
      end
    end
    for (int l = 0; l < kpbt_pkg::NUM_LANES; l++) begin
      if (match_i[l]) begin
        hi_idx = kpbt_pkg::LANE_W'(l);
      end
    end
  end

  assign any  = |match_i;
  // rows arrive in ascending order: lowest keeps the first, highest the last
  assign take = ctl_i.cmp_valid && any && (ctl_i.highest || !found_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (ctl_i.start) begin
      found_q <= 1'b0;
    end else if (take) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      slot_q <= {row_i, ctl_i.highest ? hi_idx : lo_idx};
    end
  end

  assign found_o = found_q;
  assign slot_o  = slot_q;

endmodule

FILE: rtl/core/kpbt_coord_blend.sv
module kpbt_coord_blend #(
  parameter int WEIGHT_FRAC_BITS = kpbt_pkg::WEIGHT_FRAC_DEF
) (
  input  logic                        clk_i,
  input  logic                        diff_en_i,
  input  logic                        mul_en_i,
  input  logic signed [31:0]          old_i,
  input  logic signed [31:0]          in_i,
  input  logic [WEIGHT_FRAC_BITS:0]   weight_i,
  output logic signed [31:0]          blend_o
);

  localparam int W_W    = WEIGHT_FRAC_BITS + 1;
  localparam int PROD_W = 33 + W_W + 1;
  localparam int Q_W    = PROD_W - WEIGHT_FRAC_BITS;
  localparam int SUM_W  = Q_W + 1;

  logic signed [32:0]       diff_q;
  logic signed [W_W:0]      w_s;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] biased;
  logic signed [Q_W-1:0]    q;
  logic signed [SUM_W-1:0]  sum;
  logic                     in_range;

  always_ff @(posedge clk_i) begin
    if (diff_en_i) begin
      diff_q <= $signed({in_i[31], in_i}) - $signed({old_i[31], old_i});
    end
  end

  assign w_s    = $signed({1'b0, weight_i});
  assign prod_d = PROD_W'(diff_q) * PROD_W'(w_s);

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_q <= prod_d;
    end
  end

  // truncate toward zero: bias negative products before the shift
  assign biased = prod_q + (prod_q[PROD_W-1]
                  ? PROD_W'((1 << WEIGHT_FRAC_BITS) - 1) : PROD_W'(0));
  assign q      = biased[PROD_W-1:WEIGHT_FRAC_BITS];
  assign sum    = SUM_W'(q) + SUM_W'(old_i);

  assign in_range = (sum[SUM_W-1:31] == '0) || (sum[SUM_W-1:31] == '1);

  always_comb begin
    if (in_range) begin
      blend_o = sum[31:0];
    end else if (sum[SUM_W-1]) begin
      blend_o = 32'sh8000_0000;
    end else begin
      blend_o = 32'sh7fff_ffff;
    end
  end

endmodule

FILE: rtl/core/keyed_pose_blend_table_top.sv
// the key scan checks one row of 16 lanes a cycle; a new request is taken only while
//   the block is idle, once the last result has gone to the output register
// reset: entry count, blend weight and output valid clear; table contents stay
//   undefined with no clearing pass, since only slots below the count are read
module keyed_pose_blend_table_top #(
  parameter int TABLE_DEPTH      = kpbt_pkg::TABLE_DEPTH_DEF,
  parameter int KEY_BITS         = kpbt_pkg::KEY_BITS_DEF,
  parameter int WEIGHT_FRAC_BITS = kpbt_pkg::WEIGHT_FRAC_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [WEIGHT_FRAC_BITS:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  kpbt_pkg::req_t            in_req_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output kpbt_pkg::rsp_t            out_rsp_o
);

  localparam int NL     = kpbt_pkg::NUM_LANES;
  localparam int LW     = kpbt_pkg::LANE_W;
  localparam int ROWS   = (TABLE_DEPTH + NL - 1) / NL;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SLOT_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int EXT_W  = ROW_W + LW;
  localparam int CE_W   = CNT_W + LW + ROW_W;

  kpbt_pkg::state_e     state_q, state_d;
  logic [WEIGHT_FRAC_BITS:0] weight_q;
  logic [CNT_W-1:0]     count_q, count_d;
  kpbt_pkg::req_t       req_q;
  logic [KEY_BITS-1:0]  key_q;
  logic [ROW_W-1:0]     row_q, row_d;
  logic                 cmp_valid_q;
  logic [ROW_W-1:0]     cmp_row_q;
  kpbt_pkg::rsp_t       res_q, res_d;
  kpbt_pkg::rsp_t       out_q;
  logic                 out_valid_q;
  logic [SLOT_W-1:0]    slot_q, slot_d;
  logic                 old_zero_q, old_zero_d;

  logic                 in_accept;
  logic                 out_load;
  kpbt_pkg::merge_ctl_t mctl;
  logic [NL-1:0]        match;
  logic                 found;
  logic [EXT_W-1:0]     found_slot;
  logic                 full;
  logic [SLOT_W-1:0]    fslot;
  logic [SLOT_W-1:0]    cslot;
  logic [CE_W-1:0]      cnt_ext;

  logic                 key_we;
  logic [LW-1:0]        key_wlane;
  logic [ROW_W-1:0]     key_wrow;

  kpbt_pkg::pose_t      pose_mem [TABLE_DEPTH];
  kpbt_pkg::pose_t      pose_rdata_q;
  kpbt_pkg::pose_t      pose_wdata;
  kpbt_pkg::pose_t      blend_pose;
  kpbt_pkg::pose_t      in_pose;
  logic                 pose_we;
  logic                 pose_re;
  logic [SLOT_W-1:0]    pose_waddr;
  logic [SLOT_W-1:0]    pose_raddr;
  logic                 diff_en;
  logic                 mul_en;

  assign in_ready_o = (state_q == kpbt_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign in_pose    = kpbt_pkg::req_pose(req_q);

  assign full      = (count_q == CNT_W'(TABLE_DEPTH));
  assign fslot     = SLOT_W'(found_slot);
  assign cslot     = SLOT_W'(count_q);
  assign cnt_ext   = CE_W'(count_q);
  assign key_wlane = cnt_ext[LW-1:0];
  assign key_wrow  = cnt_ext[LW +: ROW_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= '0;
    end else if (cfg_we_i) begin
      weight_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q <= in_req_i;
      key_q <= KEY_BITS'(in_req_i.part_id);
    end
  end

  // key lanes
  for (genvar l = 0; l < NL; l++) begin : g_lane
    kpbt_key_lane #(
      .KEY_BITS (KEY_BITS),
      .ROWS     (ROWS),
      .ROW_W    (ROW_W),
      .CNT_W    (CNT_W),
      .LANE_IDX (l)
    ) u_lane (
      .clk_i     (clk_i),
      .we_i      (key_we && (key_wlane == LW'(l))),
      .waddr_i   (key_wrow),
      .wkey_i    (key_q),
      .raddr_i   (row_q),
      .key_i     (key_q),
      .count_i   (count_q),
      .cmp_row_i (cmp_row_q),
      .match_o   (match[l])
    );
  end

  kpbt_merge #(
    .ROW_W (ROW_W)
  ) u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (mctl),
    .row_i   (cmp_row_q),
    .match_i (match),
    .found_o (found),
    .slot_o  (found_slot)
  );

  // one blend unit per coordinate
  for (genvar c = 0; c < kpbt_pkg::NCOORD; c++) begin : g_coord
    kpbt_coord_blend #(
      .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_blend (
      .clk_i     (clk_i),
      .diff_en_i (diff_en),
      .mul_en_i  (mul_en),
      .old_i     (old_zero_q ? 32'sd0 : pose_rdata_q[c]),
      .in_i      (in_pose[c]),
      .weight_i  (weight_q),
      .blend_o   (blend_pose[c])
    );
  end

  always_ff @(posedge clk_i) begin
    if (pose_we) begin
      pose_mem[pose_waddr] <= pose_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pose_re) begin
      pose_rdata_q <= pose_mem[pose_raddr];
    end
  end

  always_comb begin
    state_d        = state_q;
    row_d          = row_q;
    count_d        = count_q;
    res_d          = res_q;
    slot_d         = slot_q;
    old_zero_d     = old_zero_q;
    key_we         = 1'b0;
    pose_we        = 1'b0;
    pose_waddr     = slot_q;
    pose_wdata     = in_pose;
    pose_re        = 1'b0;
    pose_raddr     = fslot;
    diff_en        = 1'b0;
    mul_en         = 1'b0;
    out_load       = 1'b0;
    mctl.start     = 1'b0;
    mctl.cmp_valid = cmp_valid_q;
    mctl.highest   = (req_q.cmd == kpbt_pkg::CMD_BLEND);

    case (state_q)
      kpbt_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (in_req_i.cmd == kpbt_pkg::CMD_CLEAR) begin
            count_d = '0;
            res_d   = '0;
            state_d = kpbt_pkg::ST_RESP;
          end else begin
            row_d      = '0;
            mctl.start = 1'b1;
            state_d    = kpbt_pkg::ST_SCAN;
          end
        end
      end
      kpbt_pkg::ST_SCAN: begin
        row_d = row_q + ROW_W'(1);
        if (row_q == ROW_W'(ROWS - 1)) begin
          state_d = kpbt_pkg::ST_DRAIN;
        end
      end
      kpbt_pkg::ST_DRAIN: begin
        state_d = kpbt_pkg::ST_DECIDE;
      end
      kpbt_pkg::ST_DECIDE: begin
        res_d             = '0;
        res_d.out_part_id = kpbt_pkg::PART_W'(key_q);
        res_d.hit         = found;
        state_d           = kpbt_pkg::ST_RESP;
        case (req_q.cmd)
          kpbt_pkg::CMD_BLEND: begin
            if (found) begin
              pose_re    = 1'b1;
              slot_d     = fslot;
              old_zero_d = 1'b0;
              state_d    = kpbt_pkg::ST_DIFF;
            end else if (!full) begin
              // new entry starts from zero, written after the blend
              key_we     = 1'b1;
              count_d    = count_q + CNT_W'(1);
              slot_d     = cslot;
              old_zero_d = 1'b1;
              state_d    = kpbt_pkg::ST_DIFF;
            end else begin
              res_d.overflow = 1'b1;
            end
          end
          kpbt_pkg::CMD_LOAD: begin
            if (!full) begin
              key_we            = 1'b1;
              pose_we           = 1'b1;
              pose_waddr        = cslot;
              count_d           = count_q + CNT_W'(1);
              res_d             = kpbt_pkg::rsp_set_pose(res_d, in_pose);
              res_d.entry_index = kpbt_pkg::IDX_W'(cslot);
            end else begin
              res_d.overflow = 1'b1;
            end
          end
          kpbt_pkg::CMD_LOOKUP: begin
            if (found) begin
              pose_re = 1'b1;
              slot_d  = fslot;
              state_d = kpbt_pkg::ST_DIFF;
            end else if (req_q.add_if_missing) begin
              if (!full) begin
                key_we            = 1'b1;
                pose_we           = 1'b1;
                pose_waddr        = cslot;
                pose_wdata        = '0;
                count_d           = count_q + CNT_W'(1);
                res_d.entry_index = kpbt_pkg::IDX_W'(cslot);
              end else begin
                res_d.overflow = 1'b1;
              end
            end
          end
          default: begin
            res_d = '0;
          end
        endcase
      end
      kpbt_pkg::ST_DIFF: begin
        if (req_q.cmd == kpbt_pkg::CMD_LOOKUP) begin
          res_d             = kpbt_pkg::rsp_set_pose(res_q, pose_rdata_q);
          res_d.entry_index = kpbt_pkg::IDX_W'(slot_q);
          state_d           = kpbt_pkg::ST_RESP;
        end else begin
          diff_en = 1'b1;
          state_d = kpbt_pkg::ST_MUL;
        end
      end
      kpbt_pkg::ST_MUL: begin
        mul_en  = 1'b1;
        state_d = kpbt_pkg::ST_ADD;
      end
      kpbt_pkg::ST_ADD: begin
        pose_we           = 1'b1;
        pose_wdata        = blend_pose;
        res_d             = kpbt_pkg::rsp_set_pose(res_q, blend_pose);
        res_d.entry_index = kpbt_pkg::IDX_W'(slot_q);
        state_d           = kpbt_pkg::ST_RESP;
      end
      kpbt_pkg::ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = kpbt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = kpbt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kpbt_pkg::ST_IDLE;
      count_q     <= '0;
      row_q       <= '0;
      cmp_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      old_zero_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      row_q       <= row_d;
      cmp_valid_q <= (state_q == kpbt_pkg::ST_SCAN);
      out_valid_q <= out_load || (out_valid_q && !out_ready_i);
      old_zero_q  <= old_zero_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_row_q <= row_q;
    res_q     <= res_d;
    slot_q    <= slot_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_found_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kpbt_pkg::ST_DECIDE && found) |-> (CE_W'(found_slot) < CE_W'(count_q)))
    else $error("matched slot not below entry count");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kpbt_pkg::ST_RESP && res_q.overflow) |-> full)
    else $error("overflow reported with room in table");

  a_out_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == kpbt_pkg::ST_RESP))
    else $error("result raised outside response state");

endmodule

FILE: test/keyed_pose_blend_table_top_tb.sv
module keyed_pose_blend_table_top_tb;
  import kpbt_pkg::*;

  localparam int DEPTH           = TABLE_DEPTH_DEF;
  localparam int WFRAC           = WEIGHT_FRAC_DEF;
  localparam int SETTLE_CYCLES   = 12;
  localparam int HOLD_CYCLES     = 300;
  localparam int STUCK_LIMIT     = 2000;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int POOL_SIZE       = 6;
  localparam longint COORD_MAX   = 64'sd2147483647;
  localparam longint COORD_MIN   = -64'sd2147483648;

  typedef logic [31:0] field_vec_t [10];

  typedef struct {
    bit           set_wt;
    logic [WFRAC:0] wt;
    req_t         req;
    bit           typed;
    rsp_t         want;
  } dir_row_t;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           cfg_we_i = 1'b0;
  logic [WFRAC:0] cfg_wdata_i = '0;
  logic           in_valid_i = 1'b0;
  logic           in_ready_o;
  req_t           in_req_i = '0;
  logic           out_valid_o;
  logic           out_ready_i = 1'b0;
  rsp_t           out_rsp_o;

  keyed_pose_blend_table_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // pose table mirror
  logic [PART_W-1:0] tbl_key [DEPTH];
  pose_t             tbl_pose [DEPTH];
  int                tbl_count = 0;
  logic [WFRAC:0]    blend_wt = '0;

  rsp_t              awaited_results [$];
  dir_row_t          dir_rows [$];
  logic [PART_W-1:0] key_pool [POOL_SIZE];
  string field_name [10] = '{"out_part_id", "out_pos_x", "out_pos_y", "out_pos_z",
                             "out_rot_x", "out_rot_y", "out_rot_z", "hit", "overflow",
                             "entry_index"};

  int  errors = 0;
  int  requests_done = 0;
  int  results_checked = 0;
  int  overflow_seen = 0;
  int  weight_writes = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_req = 1'b0;
  int  hold_left = 0;
  int  stuck_cycles = 0;

  function automatic int find_slot(logic [PART_W-1:0] key, bit highest);
    int found = -1;
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_key[i] == key) begin
        found = i;
        if (!highest) break;
      end
    end
    return found;
  endfunction

  function automatic int append_entry(logic [PART_W-1:0] key, pose_t vals);
    if (tbl_count >= DEPTH) return -1;
    tbl_key[tbl_count] = key;
    tbl_pose[tbl_count] = vals;
    tbl_count++;
    return tbl_count - 1;
  endfunction

  // old + trunc((target - old) * w), saturated to 32 bits
  function automatic coord_t blend_coord(coord_t old, coord_t target);
    longint diff, mag, step, sum;
    diff = longint'(target) - longint'(old);
    mag  = (diff < 0) ? -diff : diff;
    step = (mag * longint'(blend_wt)) >>> WFRAC;
    if (diff < 0) step = -step;
    sum = longint'(old) + step;
    if (sum > COORD_MAX) sum = COORD_MAX;
    if (sum < COORD_MIN) sum = COORD_MIN;
    return coord_t'(sum);
  endfunction

  function automatic rsp_t predict_pose_result(req_t r);
    rsp_t  o;
    pose_t vin;
    pose_t p;
    int    slot;
    bit    hit;
    o = '0;
    vin[0] = r.in_pos_x;
    vin[1] = r.in_pos_y;
    vin[2] = r.in_pos_z;
    vin[3] = r.in_rot_x;
    vin[4] = r.in_rot_y;
    vin[5] = r.in_rot_z;
    case (r.cmd)
      CMD_CLEAR: begin
        tbl_count = 0;
        return o;
      end
      CMD_BLEND: begin
        slot = find_slot(r.part_id, 1'b1);
        hit = slot >= 0;
        if (!hit) slot = append_entry(r.part_id, '0);
        if (slot >= 0) begin
          for (int c = 0; c < NCOORD; c++) begin
            tbl_pose[slot][c] = blend_coord(tbl_pose[slot][c], vin[c]);
          end
        end
      end
      CMD_LOAD: begin
        hit = find_slot(r.part_id, 1'b0) >= 0;
        slot = append_entry(r.part_id, vin);
      end
      default: begin
        slot = find_slot(r.part_id, 1'b0);
        hit = slot >= 0;
        if (!hit && r.add_if_missing) begin
          slot = append_entry(r.part_id, '0);
        end else if (!hit) begin
          o.out_part_id = r.part_id;
          return o;
        end
      end
    endcase
    o.hit = hit;
    o.overflow = slot < 0;
    if (slot >= 0) begin
      p = tbl_pose[slot];
      o.out_part_id = tbl_key[slot];
      o.out_pos_x = p[0];
      o.out_pos_y = p[1];
      o.out_pos_z = p[2];
      o.out_rot_x = p[3];
      o.out_rot_y = p[4];
      o.out_rot_z = p[5];
      o.entry_index = IDX_W'(slot);
    end else begin
      o.out_part_id = r.part_id;
    end
    return o;
  endfunction

  function automatic req_t mk_req(cmd_e op, logic [PART_W-1:0] key, coord_t px, coord_t py,
                                  coord_t pz, coord_t rx, coord_t ry, coord_t rz, logic add);
    req_t r;
    r.cmd = op;
    r.part_id = key;
    r.in_pos_x = px;
    r.in_pos_y = py;
    r.in_pos_z = pz;
    r.in_rot_x = rx;
    r.in_rot_y = ry;
    r.in_rot_z = rz;
    r.add_if_missing = add;
    return r;
  endfunction

  function automatic rsp_t mk_rsp(logic [PART_W-1:0] key, coord_t px, coord_t py, coord_t pz,
                                  coord_t rx, coord_t ry, coord_t rz, logic hit, logic ovf,
                                  logic [IDX_W-1:0] idx);
    rsp_t o;
    o.out_part_id = key;
    o.out_pos_x = px;
    o.out_pos_y = py;
    o.out_pos_z = pz;
    o.out_rot_x = rx;
    o.out_rot_y = ry;
    o.out_rot_z = rz;
    o.hit = hit;
    o.overflow = ovf;
    o.entry_index = idx;
    return o;
  endfunction

  function automatic field_vec_t split_fields(rsp_t r);
    field_vec_t f;
    f[0] = 32'(r.out_part_id);
    f[1] = r.out_pos_x;
    f[2] = r.out_pos_y;
    f[3] = r.out_pos_z;
    f[4] = r.out_rot_x;
    f[5] = r.out_rot_y;
    f[6] = r.out_rot_z;
    f[7] = 32'(r.hit);
    f[8] = 32'(r.overflow);
    f[9] = 32'(r.entry_index);
    return f;
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(9))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return coord_t'($urandom_range(2000) - 1000);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic req_t rand_req(cmd_e op, logic [PART_W-1:0] key);
    return mk_req(op, key, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord(), 1'($urandom_range(1)));
  endfunction

  function automatic logic [PART_W-1:0] pick_key();
    if ($urandom_range(99) < 85) return key_pool[$urandom_range(POOL_SIZE - 1)];
    return PART_W'($urandom);
  endfunction

  function automatic cmd_e pick_cmd();
    int r;
    r = $urandom_range(99);
    if (r < 40) return CMD_BLEND;
    if (r < 60) return CMD_LOAD;
    if (r < 94) return CMD_LOOKUP;
    return CMD_CLEAR;
  endfunction

  function automatic logic [WFRAC:0] pick_weight();
    case ($urandom_range(5))
      0:       return '0;
      1:       return 17'd65536;
      2:       return '1;
      3:       return 17'($urandom_range(65535));
      4:       return 17'($urandom_range(131071));
      default: return 17'($urandom_range(16));
    endcase
  endfunction

  function automatic void new_key_pool();
    foreach (key_pool[i]) key_pool[i] = PART_W'($urandom);
  endfunction

  task automatic drive_req(req_t r, bit typed, rsp_t want);
    rsp_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= r;
    do @(posedge clk_i); while (!in_ready_o);
    pred = predict_pose_result(r);
    awaited_results.push_back(typed ? want : pred);
    requests_done++;
  endtask

  // weight changes only once the block has gone quiet
  task automatic write_weight(logic [WFRAC:0] w);
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    blend_wt = w;
    weight_writes++;
  endtask

  task automatic fill_episode(bit with_hold);
    logic [PART_W-1:0] k;
    req_t r;
    new_key_pool();
    drive_req(rand_req(CMD_CLEAR, pick_key()), 1'b0, '0);
    if (with_hold) hold_req = 1'b1;
    while (tbl_count < DEPTH) drive_req(rand_req(CMD_LOAD, pick_key()), 1'b0, '0);
    // one insert of each kind against the full table
    do k = PART_W'($urandom); while (find_slot(k, 1'b1) >= 0);
    drive_req(rand_req(CMD_BLEND, k), 1'b0, '0);
    drive_req(rand_req(CMD_LOAD, pick_key()), 1'b0, '0);
    r = rand_req(CMD_LOOKUP, k);
    r.add_if_missing = 1'b1;
    drive_req(r, 1'b0, '0);
    repeat (6) drive_req(rand_req(pick_cmd(), pick_key()), 1'b0, '0);
  endtask

  task automatic mixed_episode();
    new_key_pool();
    if ($urandom_range(1)) drive_req(rand_req(CMD_CLEAR, pick_key()), 1'b0, '0);
    repeat ($urandom_range(8, 30)) drive_req(rand_req(pick_cmd(), pick_key()), 1'b0, '0);
  endtask

  task automatic compare_result(rsp_t got);
    rsp_t       want;
    field_vec_t wf;
    field_vec_t gf;
    if (awaited_results.size() == 0) begin
      errors++;
      $display("%0t: result with nothing awaited, expected none actual %p", $time, got);
    end else begin
      want = awaited_results.pop_front();
      wf = split_fields(want);
      gf = split_fields(got);
      for (int i = 0; i < 10; i++) begin
        if (wf[i] !== gf[i]) begin
          errors++;
          $display("%0t: %s expected %h actual %h", $time, field_name[i], wf[i], gf[i]);
        end
      end
      results_checked++;
      if (got.overflow === 1'b1) overflow_seen++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) compare_result(out_rsp_o);
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stuck_cycles = 0;
    else stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding", $time,
               stuck_cycles, awaited_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int phase_base;
    int directed_count;

    // directed rows, typed results where they are obvious
    dir_rows.push_back('{1'b1, 17'd0,
      mk_req(CMD_LOOKUP, 16'h1234, 1, 2, 3, 4, 5, 6, 1'b0), 1'b1,
      mk_rsp(16'h1234, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0, 6'd0)});
    dir_rows.push_back('{1'b0, 17'd0,
      mk_req(CMD_LOOKUP, 16'h0000, -1, -1, -1, -1, -1, -1, 1'b1), 1'b1,
      mk_rsp(16'h0000, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0, 6'd0)});
    dir_rows.push_back('{1'b0, 17'd0,
      mk_req(CMD_LOAD, 16'hffff, 32'sh7fffffff, 32'sh80000000, 0, -1, 1, 32'sh00010000,
             1'b0), 1'b1,
      mk_rsp(16'hffff, 32'sh7fffffff, 32'sh80000000, 0, -1, 1, 32'sh00010000,
             1'b0, 1'b0, 6'd1)});
    // duplicate key still appends
    dir_rows.push_back('{1'b0, 17'd0,
      mk_req(CMD_LOAD, 16'hffff, 32'sh80000000, 32'sh7fffffff, 32'shffff0000, 0,
             32'sh7fffffff, 32'sh80000001, 1'b1), 1'b1,
      mk_rsp(16'hffff, 32'sh80000000, 32'sh7fffffff, 32'shffff0000, 0,
             32'sh7fffffff, 32'sh80000001, 1'b1, 1'b0, 6'd2)});
    dir_rows.push_back('{1'b0, 17'd0,
      mk_req(CMD_LOOKUP, 16'hffff, 0, 0, 0, 0, 0, 0, 1'b1), 1'b1,
      mk_rsp(16'hffff, 32'sh7fffffff, 32'sh80000000, 0, -1, 1, 32'sh00010000,
             1'b1, 1'b0, 6'd1)});
    dir_rows.push_back('{1'b0, 17'd0,
      mk_req(CMD_BLEND, 16'hffff, 0, 0, 0, 0, 0, 0, 1'b0), 1'b0, '0});
    dir_rows.push_back('{1'b0, 17'd0,
      mk_req(CMD_BLEND, 16'h8000, 100, -100, 7, -7, 32'sh7fffffff, 32'sh80000000, 1'b1),
      1'b1, mk_rsp(16'h8000, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0, 6'd3)});
    dir_rows.push_back('{1'b0, 17'd0,
      mk_req(CMD_CLEAR, 16'hffff, -1, -1, -1, -1, -1, -1, 1'b1), 1'b1, '0});
    dir_rows.push_back('{1'b0, 17'd0,
      mk_req(CMD_LOOKUP, 16'hffff, 0, 0, 0, 0, 0, 0, 1'b1), 1'b1,
      mk_rsp(16'hffff, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0, 6'd0)});
    // full weight takes the incoming pose
    dir_rows.push_back('{1'b1, 17'd65536,
      mk_req(CMD_BLEND, 16'hffff, 32'sh7fffffff, 32'sh80000000, 0, -1, 1, 32'sh00010000,
             1'b0), 1'b1,
      mk_rsp(16'hffff, 32'sh7fffffff, 32'sh80000000, 0, -1, 1, 32'sh00010000,
             1'b1, 1'b0, 6'd0)});
    // weight above one extrapolates into saturation both ways
    dir_rows.push_back('{1'b1, 17'h1ffff,
      mk_req(CMD_BLEND, 16'hffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
             32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1'b0), 1'b0, '0});
    dir_rows.push_back('{1'b0, 17'd0,
      mk_req(CMD_BLEND, 16'hffff, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
             32'sh80000000, 32'sh7fffffff, 32'sh80000000, 1'b0), 1'b0, '0});
    dir_rows.push_back('{1'b1, 17'd1,
      mk_req(CMD_BLEND, 16'hffff, 32'sh00012345, -32'sh00012345, 0, 1, -1, 32'sh40000000,
             1'b0), 1'b0, '0});
    // half weight, truncation toward zero on odd differences
    dir_rows.push_back('{1'b1, 17'd32768,
      mk_req(CMD_BLEND, 16'h5a5a, -3, 3, -1, 1, 32'sh7fffffff, 32'sh80000000, 1'b0),
      1'b0, '0});
    dir_rows.push_back('{1'b0, 17'd0,
      mk_req(CMD_LOAD, 16'h5a5a, 11, -11, 22, -22, 33, -33, 1'b0), 1'b0, '0});
    dir_rows.push_back('{1'b0, 17'd0,
      mk_req(CMD_LOOKUP, 16'h5a5a, 0, 0, 0, 0, 0, 0, 1'b1), 1'b0, '0});
    dir_rows.push_back('{1'b0, 17'd0,
      mk_req(CMD_LOOKUP, 16'ha5a5, 5, 5, 5, 5, 5, 5, 1'b0), 1'b1,
      mk_rsp(16'ha5a5, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0, 6'd0)});
    dir_rows.push_back('{1'b0, 17'd0,
      mk_req(CMD_CLEAR, 16'h0000, 0, 0, 0, 0, 0, 0, 1'b0), 1'b1, '0});

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_wt) write_weight(dir_rows[i].wt);
      drive_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
    end
    directed_count = requests_done;

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      phase_base = requests_done;
      write_weight(pick_weight());
      fill_episode(ph == 0);
      while (requests_done - phase_base < ITEMS_PER_PHASE) begin
        write_weight(pick_weight());
        mixed_episode();
      end
    end

    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (awaited_results.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, awaited_results.size());
    end

    $display("run: %0d requests (%0d directed), %0d results checked, %0d overflows",
             requests_done, directed_count, results_checked, overflow_seen);
    $display("run: %0d weight writes over four handshake pacing phases", weight_writes);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
